/* hdl/civil_date_day_count_converter_defines.svh */
// Assertion macros shared by the checker of the civil date converter.
// Depends on nothing; the using module must provide clk and rst signals.
`ifndef CIVIL_DATE_DAY_COUNT_CONVERTER_DEFINES_SVH
`define CIVIL_DATE_DAY_COUNT_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CDDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CDDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cddc_pkg.sv */
// Package for the civil date converter: calendar constants, leap-year and
// month-length helpers, controller state type and control/status structs.
package cddc_pkg;

  localparam int YEAR_BITS  = 12;
  localparam int YCNT_BITS  = 13;   // year counter; holds years past 4095
  localparam int MONTH_BITS = 4;
  localparam int DAY_BITS   = 5;
  localparam int LEN_BITS   = 9;    // holds a year length
  localparam int SUM_BITS   = 21;   // date-to-days accumulator
  localparam int Q_BITS     = 6;    // year / 100 for years below 4096
  localparam int PROD_BITS  = 25;   // year times reciprocal of 100

  localparam logic [YCNT_BITS-1:0]  EPOCH_YEAR  = 13'd1970;
  localparam logic [1:0]            EPOCH_MOD4  = 2'd2;
  localparam logic [6:0]            EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]            EPOCH_MOD400 = 9'd370;
  localparam logic [6:0]            MOD100_LAST = 7'd99;
  localparam logic [8:0]            MOD400_LAST = 9'd399;
  localparam logic [12:0]           CENTURY     = 13'd100;

  // floor(y * 5243 / 2^19) equals floor(y / 100) for every 12-bit year.
  localparam logic [12:0]           RECIP_100   = 13'd5243;
  localparam int                    RECIP_SHIFT = 19;

  localparam logic [LEN_BITS-1:0]   DAYS_LEAP   = 9'd366;
  localparam logic [LEN_BITS-1:0]   DAYS_COMMON = 9'd365;
  localparam logic [DAY_BITS-1:0]   FEB_LEAP_DAYS = 5'd29;
  localparam logic [MONTH_BITS-1:0] FIRST_MONTH = 4'd1;
  localparam logic [MONTH_BITS-1:0] FEBRUARY    = 4'd2;
  localparam logic [MONTH_BITS-1:0] LAST_MONTH  = 4'd12;
  localparam logic [MONTH_BITS-1:0] MONTH_LIMIT = 4'd13;

  localparam logic [DAY_BITS-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic year_step;
    logic month_step;
    logic finish;
  } dp_cmd_t;

  // Loop conditions from the datapath to the controller.
  typedef struct packed {
    logic year_more;
    logic month_more;
  } dp_sts_t;

  // Leap year from the year's residues modulo 4, 100 and 400.
  function automatic logic leap_from_mods(input logic [1:0] m4,
                                          input logic [6:0] m100,
                                          input logic [8:0] m400);
    return ((m4 == 2'd0) && (m100 != 7'd0)) || (m400 == 9'd0);
  endfunction

  function automatic logic [LEN_BITS-1:0] year_len(input logic leap);
    return leap ? DAYS_LEAP : DAYS_COMMON;
  endfunction

  // Days in month m (1 to 12); other month codes give zero.
  function automatic logic [DAY_BITS-1:0] month_days(input logic [MONTH_BITS-1:0] m,
                                                     input logic leap);
    logic [MONTH_BITS-1:0] idx;
    logic [DAY_BITS-1:0]   d;
    idx = m - FIRST_MONTH;
    if ((m >= FIRST_MONTH) && (m <= LAST_MONTH)) begin
      d = MONTH_LEN[idx];
    end else begin
      d = '0;
    end
    if ((m == FEBRUARY) && leap) begin
      d = FEB_LEAP_DAYS;
    end
    return d;
  endfunction

endpackage

/* hdl/cddc_req_if.sv */
// Request channel of the civil date converter: valid/ready plus the
// conversion request fields. Depends on cddc_pkg for field widths.
interface cddc_req_if #(
  parameter int DAY_COUNT_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic [DAY_COUNT_BITS-1:0]           day_count_in;
  logic [cddc_pkg::YEAR_BITS-1:0]      year_in;
  logic [cddc_pkg::MONTH_BITS-1:0]     month_in;
  logic [cddc_pkg::DAY_BITS-1:0]       day_in;

  modport source (output valid, func, day_count_in, year_in, month_in, day_in,
                  input ready);
  modport sink   (input valid, func, day_count_in, year_in, month_in, day_in,
                  output ready);
endinterface

/* hdl/cddc_rsp_if.sv */
// Response channel of the civil date converter: valid/ready plus the
// conversion result fields. Depends on cddc_pkg for field widths.
interface cddc_rsp_if #(
  parameter int DAY_COUNT_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic [cddc_pkg::YEAR_BITS-1:0]      year_out;
  logic [cddc_pkg::MONTH_BITS-1:0]     month_out;
  logic [cddc_pkg::DAY_BITS-1:0]       day_out;
  logic [DAY_COUNT_BITS-1:0]           day_count_out;
  logic                                out_of_range;

  modport source (output valid, year_out, month_out, day_out, day_count_out,
                  out_of_range, input ready);
  modport sink   (input valid, year_out, month_out, day_out, day_count_out,
                  out_of_range, output ready);
endinterface

/* hdl/cddc_ctrl.sv */
// Controller of the civil date converter: sequences the year loop, the month
// loop and the result handoff. Depends on cddc_pkg (state_t, command structs).
module cddc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  cddc_pkg::dp_sts_t sts,
  output cddc_pkg::dp_cmd_t cmd
);

  cddc_pkg::state_t state;
  cddc_pkg::state_t state_next;
  logic             out_valid;
  logic             out_valid_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cddc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The result register is full from handoff until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      cddc_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = cddc_pkg::ST_YEAR;
        end
      end
      cddc_pkg::ST_YEAR: begin
        if (sts.year_more) begin
          cmd.year_step = 1'b1;
        end else begin
          state_next = cddc_pkg::ST_MONTH;
        end
      end
      cddc_pkg::ST_MONTH: begin
        if (sts.month_more) begin
          cmd.month_step = 1'b1;
        end else begin
          state_next = cddc_pkg::ST_FINISH;
        end
      end
      cddc_pkg::ST_FINISH: begin
        // Wait until the previous result has left the output register.
        if (!out_valid || rsp_ready) begin
          cmd.finish = 1'b1;
          state_next = cddc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cddc_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid follows the result register occupancy.
  always_comb begin
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (rsp_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign rsp_valid = out_valid;

endmodule

/* hdl/cddc_dp.sv */
// Datapath of the civil date converter: year and month counters, remaining
// day count, running sum and the result register. Depends on cddc_pkg.
module cddc_dp #(
  parameter int DAY_COUNT_BITS = 16
) (
  input  logic                              clk,
  input  cddc_pkg::dp_cmd_t                 cmd,
  output cddc_pkg::dp_sts_t                 sts,
  input  logic                              func,
  input  logic [DAY_COUNT_BITS-1:0]         day_count_in,
  input  logic [cddc_pkg::YEAR_BITS-1:0]    year_in,
  input  logic [cddc_pkg::MONTH_BITS-1:0]   month_in,
  input  logic [cddc_pkg::DAY_BITS-1:0]     day_in,
  output logic [cddc_pkg::YEAR_BITS-1:0]    year_out,
  output logic [cddc_pkg::MONTH_BITS-1:0]   month_out,
  output logic [cddc_pkg::DAY_BITS-1:0]     day_out,
  output logic [DAY_COUNT_BITS-1:0]         day_count_out,
  output logic                              out_of_range
);

  localparam int SW = cddc_pkg::SUM_BITS;
  localparam logic [DAY_COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SW-1:0] COUNT_MAX_W = SW'(COUNT_MAX);
  // Once the running sum reaches this, the result saturates regardless of
  // the months and day still to be added.
  localparam logic [SW-1:0] SAT_LIMIT = COUNT_MAX_W + SW'(2);

  logic                                func_r;
  logic [DAY_COUNT_BITS-1:0]           rem;
  logic [cddc_pkg::YCNT_BITS-1:0]      yr;
  logic [cddc_pkg::MONTH_BITS-1:0]     mon;
  logic [1:0]                          mod4;
  logic [6:0]                          mod100;
  logic [8:0]                          mod400;
  logic [cddc_pkg::YEAR_BITS-1:0]      yin;
  logic [cddc_pkg::MONTH_BITS-1:0]     lim;
  logic [cddc_pkg::DAY_BITS-1:0]       din;
  logic [cddc_pkg::Q_BITS-1:0]         q100;
  logic [SW-1:0]                       sum;

  logic [cddc_pkg::PROD_BITS-1:0]      recip_prod;
  logic [12:0]                         q_times_100;
  logic                                cent_year;
  logic                                yin_leap;
  logic                                cnt_leap;
  logic [cddc_pkg::LEN_BITS-1:0]       ylen;
  logic [cddc_pkg::DAY_BITS-1:0]       mlen;
  logic [SW-1:0]                       total;

  // Year / 100 by reciprocal multiply, registered at load.
  assign recip_prod = cddc_pkg::PROD_BITS'(year_in) * cddc_pkg::PROD_BITS'(cddc_pkg::RECIP_100);

  // Leap rule for the requested year from its quotient by 100.
  assign q_times_100 = 13'(q100) * cddc_pkg::CENTURY;
  assign cent_year   = ({1'b0, yin} == q_times_100);
  assign yin_leap    = ((yin[1:0] == 2'd0) && !cent_year) ||
                       (cent_year && (q100[1:0] == 2'd0));

  // Leap rule for the year counter from its tracked residues.
  assign cnt_leap = cddc_pkg::leap_from_mods(mod4, mod100, mod400);
  assign ylen     = cddc_pkg::year_len(cnt_leap);
  assign mlen     = cddc_pkg::month_days(mon, func_r ? yin_leap : cnt_leap);
  assign total    = sum + SW'(din);

  // Loop conditions for the controller.
  always_comb begin
    if (func_r) begin
      sts.year_more  = ({1'b0, yin} > yr) && (sum < SAT_LIMIT);
      sts.month_more = (mon < lim);
    end else begin
      sts.year_more  = (rem >= DAY_COUNT_BITS'(ylen));
      sts.month_more = (mon < cddc_pkg::LAST_MONTH) && (rem >= DAY_COUNT_BITS'(mlen));
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      rem    <= day_count_in;
      yr     <= cddc_pkg::EPOCH_YEAR;
      mon    <= cddc_pkg::FIRST_MONTH;
      mod4   <= cddc_pkg::EPOCH_MOD4;
      mod100 <= cddc_pkg::EPOCH_MOD100;
      mod400 <= cddc_pkg::EPOCH_MOD400;
      yin    <= year_in;
      lim    <= (month_in > cddc_pkg::LAST_MONTH) ? cddc_pkg::MONTH_LIMIT : month_in;
      din    <= day_in;
      q100   <= recip_prod[cddc_pkg::RECIP_SHIFT +: cddc_pkg::Q_BITS];
      sum    <= '0;
    end else if (cmd.year_step) begin
      if (func_r) begin
        sum <= sum + SW'(ylen);
      end else begin
        rem <= rem - DAY_COUNT_BITS'(ylen);
      end
      yr     <= yr + cddc_pkg::YCNT_BITS'(1);
      mod4   <= mod4 + 2'd1;
      mod100 <= (mod100 == cddc_pkg::MOD100_LAST) ? 7'd0 : mod100 + 7'd1;
      mod400 <= (mod400 == cddc_pkg::MOD400_LAST) ? 9'd0 : mod400 + 9'd1;
    end else if (cmd.month_step) begin
      if (func_r) begin
        sum <= sum + SW'(mlen);
      end else begin
        rem <= rem - DAY_COUNT_BITS'(mlen);
      end
      mon <= mon + 4'd1;
    end
  end

  // Result register, loaded at handoff.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (func_r) begin
        year_out  <= '0;
        month_out <= '0;
        day_out   <= '0;
        if (total == '0) begin
          day_count_out <= '0;
          out_of_range  <= 1'b1;
        end else if ((total - SW'(1)) > COUNT_MAX_W) begin
          day_count_out <= COUNT_MAX;
          out_of_range  <= 1'b1;
        end else begin
          day_count_out <= DAY_COUNT_BITS'(total - SW'(1));
          out_of_range  <= 1'b0;
        end
      end else begin
        year_out      <= yr[cddc_pkg::YEAR_BITS-1:0];
        month_out     <= mon;
        day_out       <= rem[cddc_pkg::DAY_BITS-1:0] + 5'd1;
        day_count_out <= '0;
        out_of_range  <= 1'b0;
      end
    end
  end

endmodule

/* hdl/civil_date_day_count_converter.sv */
// Civil date converter between days since 1970-01-01 and Gregorian dates.
// Request channel req: func 0 turns day_count_in into year/month/day,
// func 1 turns year_in/month_in/day_in into a saturated day count.
// Response channel rsp carries exactly one result per request; the fields
// of the direction not taken read zero.
// The response is valid once the year loop, the month loop and the handoff
// are done. The year loop steps each whole year (elapsed years from 1970,
// or year_in - 1970) and adds or subtracts one year length per cycle; the
// month loop then steps the months. Date-to-days stops stepping years once
// the sum is known to saturate.
// One request is in flight at a time; a new request is accepted as soon as
// the previous result sits in the output register, even while it waits.
// When the receiver stalls, the result holds and the next result waits in
// the datapath until the output register is free.
// Reset (synchronous, active high) returns to idle and empties the output.
module civil_date_day_count_converter #(
  parameter int DAY_COUNT_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  cddc_req_if.sink  req,
  cddc_rsp_if.source rsp
);

  cddc_pkg::dp_cmd_t cmd;
  cddc_pkg::dp_sts_t sts;

  cddc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cddc_dp #(
    .DAY_COUNT_BITS (DAY_COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .func          (req.func),
    .day_count_in  (req.day_count_in),
    .year_in       (req.year_in),
    .month_in      (req.month_in),
    .day_in        (req.day_in),
    .year_out      (rsp.year_out),
    .month_out     (rsp.month_out),
    .day_out       (rsp.day_out),
    .day_count_out (rsp.day_count_out),
    .out_of_range  (rsp.out_of_range)
  );

endmodule

/* hdl/cddc_checker.sv */
// Port-level checker for the civil date converter and its bind statement.
// Depends on cddc_pkg and civil_date_day_count_converter_defines.svh.
`include "civil_date_day_count_converter_defines.svh"

module cddc_checker #(
  parameter int DAY_COUNT_BITS = 16
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [cddc_pkg::YEAR_BITS-1:0]  year_out,
  input logic [cddc_pkg::MONTH_BITS-1:0] month_out,
  input logic [cddc_pkg::DAY_BITS-1:0]   day_out,
  input logic [DAY_COUNT_BITS-1:0]       day_count_out,
  input logic                            out_of_range
);

  // A stalled response stays offered with the same fields.
  `CDDC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
  `CDDC_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable({year_out, month_out, day_out, day_count_out, out_of_range}), "stalled response changed")

  // Only one request is worked on at a time.
  `CDDC_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")

  // A result carries either a date or a day count, never both.
  `CDDC_ASSERT_NOW(a_one_direction, rsp_valid, ((year_out == '0) && (month_out == '0) && (day_out == '0)) || ((day_count_out == '0) && !out_of_range), "result mixes both directions")

  // A produced date has a month in range and a nonzero day.
  `CDDC_ASSERT_NOW(a_date_sane, rsp_valid && (month_out != '0), (month_out <= cddc_pkg::LAST_MONTH) && (day_out != '0), "malformed date")

endmodule

bind civil_date_day_count_converter cddc_checker #(
  .DAY_COUNT_BITS (DAY_COUNT_BITS)
) u_cddc_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .year_out      (rsp.year_out),
  .month_out     (rsp.month_out),
  .day_out       (rsp.day_out),
  .day_count_out (rsp.day_count_out),
  .out_of_range  (rsp.out_of_range)
);

/* tb/sv/tb_civil_date_day_count_converter.sv */
`timescale 1ns / 1ps
// Testbench for civil_date_day_count_converter: random and directed conversion requests,
// with results predicted in both directions and checked field by field.
// Depends on cddc_pkg, cddc_req_if, cddc_rsp_if and the converter RTL.
module tb_civil_date_day_count_converter;

  localparam int DCB = 16;
  localparam int unsigned COUNT_MAX = (1 << DCB) - 1;
  localparam int unsigned EPOCH_YEAR = 1970;
  localparam int unsigned MAX_WAIT = 13;
  localparam logic FUNC_DAYS_TO_DATE = 1'b0;
  localparam logic FUNC_DATE_TO_DAYS = 1'b1;
  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic                             func;
    logic [DCB-1:0]                   day_count;
    logic [cddc_pkg::YEAR_BITS-1:0]   year;
    logic [cddc_pkg::MONTH_BITS-1:0]  month;
    logic [cddc_pkg::DAY_BITS-1:0]    day;
  } conv_request_t;

  typedef struct packed {
    logic [cddc_pkg::YEAR_BITS-1:0]   year;
    logic [cddc_pkg::MONTH_BITS-1:0]  month;
    logic [cddc_pkg::DAY_BITS-1:0]    day;
    logic [DCB-1:0]                   day_count;
    logic                             out_of_range;
  } conv_result_t;

  logic clk;
  logic rst;

  cddc_req_if #(.DAY_COUNT_BITS(DCB)) req_ch ();
  cddc_rsp_if #(.DAY_COUNT_BITS(DCB)) rsp_ch ();

  civil_date_day_count_converter #(.DAY_COUNT_BITS(DCB)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  conv_request_t pending_requests [$];
  conv_result_t  expected_results [$];
  int unsigned   fail_count = 0;
  int unsigned   send_wait;
  int unsigned   recv_wait;
  bit            send_calm = 1'b0;
  bit            recv_calm = 1'b0;
  bit            recv_free_run = 1'b0;

  // Gregorian leap rule: every fourth year, except centuries not divisible by 400.
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_year(input int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  // Month m is 1 to 12.
  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    int unsigned d;
    d = MONTH_DAYS[m - 1];
    if (m == 2 && leap_year(y)) begin
      d = 29;
    end
    return d;
  endfunction

  // Expected result of one request; fields of the other direction stay zero.
  function automatic conv_result_t convert_request(input conv_request_t r);
    conv_result_t res;
    int unsigned rem;
    int unsigned yr;
    int unsigned mon;
    int unsigned total;
    int unsigned lim;
    res = '0;
    if (r.func == FUNC_DAYS_TO_DATE) begin
      rem = 32'(r.day_count);
      yr = EPOCH_YEAR;
      mon = 1;
      while (rem >= days_in_year(yr)) begin
        rem -= days_in_year(yr);
        yr++;
      end
      while (mon < 12 && rem >= month_length(yr, mon)) begin
        rem -= month_length(yr, mon);
        mon++;
      end
      res.year  = yr[cddc_pkg::YEAR_BITS-1:0];
      res.month = mon[cddc_pkg::MONTH_BITS-1:0];
      res.day   = cddc_pkg::DAY_BITS'(rem + 1);
    end else begin
      // The running total is one above the day count, so day zero can go below zero.
      total = 0;
      for (yr = EPOCH_YEAR; yr < 32'(r.year); yr++) begin
        total += days_in_year(yr);
      end
      lim = (r.month > 12) ? 13 : 32'(r.month);
      for (mon = 1; mon < lim; mon++) begin
        total += month_length(32'(r.year), mon);
      end
      total += 32'(r.day);
      if (total == 0) begin
        res.out_of_range = 1'b1;
      end else if (total - 1 > COUNT_MAX) begin
        res.day_count = COUNT_MAX[DCB-1:0];
        res.out_of_range = 1'b1;
      end else begin
        res.day_count = DCB'(total - 1);
      end
    end
    return res;
  endfunction

  // Unused fields of each request carry random values so every bit toggles.
  task automatic queue_days_to_date(input int unsigned count);
    conv_request_t r;
    r.func      = FUNC_DAYS_TO_DATE;
    r.day_count = DCB'(count);
    r.year      = cddc_pkg::YEAR_BITS'($urandom);
    r.month     = cddc_pkg::MONTH_BITS'($urandom);
    r.day       = cddc_pkg::DAY_BITS'($urandom);
    pending_requests.push_back(r);
  endtask

  task automatic queue_date_to_days(input int unsigned y, input int unsigned m,
                                    input int unsigned d);
    conv_request_t r;
    r.func      = FUNC_DATE_TO_DAYS;
    r.day_count = DCB'($urandom);
    r.year      = cddc_pkg::YEAR_BITS'(y);
    r.month     = cddc_pkg::MONTH_BITS'(m);
    r.day       = cddc_pkg::DAY_BITS'(d);
    pending_requests.push_back(r);
  endtask

  // Mostly well-formed dates and full-range counts, with some malformed fields.
  task automatic queue_random(input int unsigned n);
    int unsigned sel;
    int unsigned y;
    int unsigned m;
    repeat (n) begin
      sel = $urandom_range(0, 9);
      if ($urandom_range(0, 1) == 0) begin
        if (sel < 6) begin
          queue_days_to_date($urandom_range(0, COUNT_MAX));
        end else if (sel < 8) begin
          queue_days_to_date($urandom_range(0, 1500));
        end else begin
          queue_days_to_date($urandom_range(COUNT_MAX - 1500, COUNT_MAX));
        end
      end else begin
        if (sel < 7) begin
          y = $urandom_range(1970, 2149);
          m = $urandom_range(1, 12);
          queue_date_to_days(y, m, $urandom_range(1, month_length(y, m)));
        end else if (sel == 7) begin
          queue_date_to_days($urandom_range(1970, 2149), $urandom_range(0, 15),
                             $urandom_range(0, 31));
        end else if (sel == 8) begin
          queue_date_to_days($urandom_range(0, 4095), $urandom_range(0, 15),
                             $urandom_range(0, 31));
        end else begin
          queue_date_to_days($urandom_range(2140, 2149), $urandom_range(1, 12),
                             $urandom_range(0, 31));
        end
      end
    end
  endtask

  // Sampled on the falling edge, so queue updates at the rising edge have settled.
  task automatic wait_for_drain();
    do begin
      @(negedge clk);
    end while (pending_requests.size() != 0 || req_ch.valid || expected_results.size() != 0);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request driver: holds each request until accepted, then waits a drawn gap.
  always @(posedge clk) begin : request_driver
    conv_request_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_wait <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (send_wait != 0) begin
        req_ch.valid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (pending_requests.size() != 0) begin
        nxt = pending_requests.pop_front();
        req_ch.func         <= nxt.func;
        req_ch.day_count_in <= nxt.day_count;
        req_ch.year_in      <= nxt.year;
        req_ch.month_in     <= nxt.month;
        req_ch.day_in       <= nxt.day;
        req_ch.valid        <= 1'b1;
        if ($urandom_range(0, 49) == 0) begin
          send_calm = !send_calm;
        end
        send_wait <= send_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: after each result, holds ready low for a drawn number of cycles,
  // counted either from once the next result shows up or right away.
  always @(posedge clk) begin : result_receiver
    int unsigned stall;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_wait <= 0;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      if ($urandom_range(0, 49) == 0) begin
        recv_calm = !recv_calm;
      end
      recv_free_run = ($urandom_range(0, 1) != 0);
      stall = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
      recv_wait <= stall;
      rsp_ch.ready <= (stall == 0);
    end else if (recv_wait == 0) begin
      rsp_ch.ready <= 1'b1;
    end else if (rsp_ch.valid || recv_free_run) begin
      recv_wait <= recv_wait - 1;
      rsp_ch.ready <= (recv_wait == 1);
    end
  end

  // Monitor: checks each result against the oldest prediction, then records
  // the prediction for a request accepted at this edge.
  always @(posedge clk) begin : result_monitor
    conv_request_t seen;
    conv_result_t  want;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: year %0d month %0d day %0d count %0d",
                 rsp_ch.year_out, rsp_ch.month_out, rsp_ch.day_out, rsp_ch.day_count_out);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("year_out", 32'(want.year), 32'(rsp_ch.year_out));
          compare_field("month_out", 32'(want.month), 32'(rsp_ch.month_out));
          compare_field("day_out", 32'(want.day), 32'(rsp_ch.day_out));
          compare_field("day_count_out", 32'(want.day_count), 32'(rsp_ch.day_count_out));
          compare_field("out_of_range", 32'(want.out_of_range), 32'(rsp_ch.out_of_range));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        seen.func      = req_ch.func;
        seen.day_count = req_ch.day_count_in;
        seen.year      = req_ch.year_in;
        seen.month     = req_ch.month_in;
        seen.day       = req_ch.day_in;
        expected_results.push_back(convert_request(seen));
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_DAYS_TO_DATE;
    req_ch.day_count_in = '0;
    req_ch.year_in = '0;
    req_ch.month_in = '0;
    req_ch.day_in = '0;
    rsp_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Days to date: epoch, year ends, leap days including the 400 and 100 rules, maximum.
    queue_days_to_date(0);
    queue_days_to_date(364);
    queue_days_to_date(365);
    queue_days_to_date(789);
    queue_days_to_date(790);
    queue_days_to_date(11016);
    queue_days_to_date(47540);
    queue_days_to_date(47541);
    queue_days_to_date(COUNT_MAX - 1);
    queue_days_to_date(COUNT_MAX);
    // Date to days: epoch, sums below zero, early years, odd months and days, saturation.
    queue_date_to_days(1970, 1, 1);
    queue_date_to_days(1970, 1, 0);
    queue_date_to_days(1969, 1, 0);
    queue_date_to_days(0, 0, 0);
    queue_date_to_days(1960, 3, 29);
    queue_date_to_days(1972, 0, 15);
    queue_date_to_days(1999, 13, 5);
    queue_date_to_days(2001, 15, 31);
    queue_date_to_days(2021, 2, 31);
    queue_date_to_days(2000, 2, 29);
    queue_date_to_days(2100, 3, 1);
    queue_date_to_days(2149, 6, 6);
    queue_date_to_days(2149, 6, 7);
    queue_date_to_days(4095, 15, 31);
    wait_for_drain();

    // Random requests, with a full drain halfway so the converter runs empty once.
    queue_random(725);
    wait_for_drain();
    queue_random(725);
    wait_for_drain();

    repeat (250) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/cddc_pkg.sv
hdl/cddc_req_if.sv
hdl/cddc_rsp_if.sv
hdl/cddc_ctrl.sv
hdl/cddc_dp.sv
hdl/civil_date_day_count_converter.sv
hdl/cddc_checker.sv
tb/sv/tb_civil_date_day_count_converter.sv
